>>> hdl/bsm3_pkg.sv
// Shared types, constants and pixel arithmetic for the 3x3 binomial RGB smoother.
// Depends on nothing; every other file of the block imports it.

package bsm3_pkg;

   // Pixel word: channel 0 in bits 7..0, channel 1 in 15..8, channel 2 in 23..16
   localparam int CHANNELS   = 3;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = CHANNELS * CHAN_W;
   localparam int COORD_W    = 11;
   localparam int CFG_W      = 12;
   localparam int CSR_AW     = 2;

   // Defaults for the top-level parameters and the size registers
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;
   localparam int DEF_WIDTH      = 640;
   localparam int DEF_HEIGHT     = 480;
   localparam int MIN_SIZE       = 3;

   // Result queue sizing: one pixel causes up to three results
   localparam int MAX_RESULTS = 3;
   localparam int OUTQ_DEPTH  = 8;
   localparam int OUTQ_AW     = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CW     = $clog2(OUTQ_DEPTH + 1);

   typedef logic [PIX_W-1:0] pixel_type;

   // Vertical column of the window: [0] row y-2, [1] row y-1, [2] row y
   typedef logic [2:0][PIX_W-1:0] column_type;

   typedef enum logic [CSR_AW-1:0] {
      REG_IMAGE_WIDTH  = 2'd0,
      REG_IMAGE_HEIGHT = 2'd1
   } csr_reg_type;

   // One line-buffer entry: the rows y-2 and y-1 at a column
   typedef struct packed {
      pixel_type prev2;
      pixel_type prev;
   } linepair_type;

   // Position flags of an accepted pixel
   typedef struct packed {
      logic x_is0;
      logic x_is1;
      logic y_is0;
      logic y_ge2;
      logic last_col;
      logic last_row;
   } pos_flags_type;

   typedef struct packed {
      pixel_type          pix;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last_of_item;
   } rsp_entry_type;

   // Results of one pixel, packed from entry 0 upward
   typedef struct packed {
      logic [1:0]                          cnt;
      rsp_entry_type [MAX_RESULTS-1:0]     ent;
   } push_type;

   // Saturate a size register into [MIN_SIZE, maxv]
   function automatic int clamp_size(logic [CFG_W-1:0] v, int maxv);
      if (int'(v) < MIN_SIZE) return MIN_SIZE;
      if (int'(v) > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic logic [11:0] chan12(pixel_type p, int ch);
      return 12'(p[CHAN_W*ch +: CHAN_W]);
   endfunction

   // Kernel [1 2 1] down a column, (sum + 2) >> 2 per channel
   function automatic pixel_type vert_pix(column_type c);
      pixel_type   res;
      logic [11:0] s;
      res = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         s = chan12(c[0], ch) + (chan12(c[1], ch) << 1) + chan12(c[2], ch) + 12'd2;
         res[CHAN_W*ch +: CHAN_W] = s[9:2];
      end
      return res;
   endfunction

   // Kernel [1 2 1; 2 4 2; 1 2 1], (sum + 8) >> 4 per channel
   function automatic pixel_type full_pix(column_type l, column_type c, column_type r);
      pixel_type   res;
      logic [11:0] s;
      res = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         s = chan12(l[0], ch) + (chan12(c[0], ch) << 1) + chan12(r[0], ch)
           + (chan12(l[1], ch) << 1) + (chan12(c[1], ch) << 2) + (chan12(r[1], ch) << 1)
           + chan12(l[2], ch) + (chan12(c[2], ch) << 1) + chan12(r[2], ch) + 12'd8;
         res[CHAN_W*ch +: CHAN_W] = s[11:4];
      end
      return res;
   endfunction

endpackage

>>> hdl/bsm3_linebuf.sv
// Line buffer memory: rows y-2 and y-1 side by side, one entry per column.
// Synchronous read: the read data is registered. Depends on bsm3_pkg.

module bsm3_linebuf #(
   parameter int DEPTH = bsm3_pkg::MAX_WIDTH_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [AW-1:0]          rd_addr,
   output bsm3_pkg::linepair_type rd_data_ff,
   input  logic                   wr_en,
   input  logic [AW-1:0]          wr_addr,
   input  bsm3_pkg::linepair_type wr_data
);
   import bsm3_pkg::*;

   linepair_type mem [DEPTH];

   // Write back the rotated pair, read the next column
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

>>> hdl/bsm3_filter.sv
// Filter stage: holds the accepted pixel while the line buffer answers, forms
// the window column, computes up to three results and writes the buffer back.
// Depends on bsm3_pkg.

module bsm3_filter #(
   parameter int MAX_WIDTH  = bsm3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bsm3_pkg::MAX_HEIGHT_DEF,
   parameter int COL_W      = $clog2(MAX_WIDTH),
   parameter int ROW_W      = $clog2(MAX_HEIGHT)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  bsm3_pkg::pixel_type     pix,
   input  logic [COL_W-1:0]        x,
   input  logic [ROW_W-1:0]        y,
   input  bsm3_pkg::pos_flags_type flags,
   input  bsm3_pkg::linepair_type  lb_rd_data,
   output logic                    lb_wr_en,
   output logic [COL_W-1:0]        lb_wr_addr,
   output bsm3_pkg::linepair_type  lb_wr_data,
   output logic                    stage_valid,
   output bsm3_pkg::push_type      push
);
   import bsm3_pkg::*;

   logic          stage_valid_ff;
   pixel_type     pix_ff;
   logic [COL_W-1:0] x_ff;
   logic [ROW_W-1:0] y_ff;
   pos_flags_type flags_ff;
   column_type    left_ff;
   column_type    center_ff;
   column_type    cur;
   rsp_entry_type ent_a;
   rsp_entry_type ent_b;
   rsp_entry_type ent_c;
   logic          va;
   logic          vb;
   logic          vc;
   logic [1:0]    idx;

   // Stage register: one pixel, advances every cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff   <= pix;
         x_ff     <= x;
         y_ff     <= y;
         flags_ff <= flags;
      end
   end

   // Shift the window by one column per processed pixel
   always_ff @(posedge clock) begin
      if (stage_valid_ff) begin
         left_ff   <= center_ff;
         center_ff <= cur;
      end
   end

   assign cur = {pix_ff, lb_rd_data.prev, lb_rd_data.prev2};

   // Rotate the rows at this column: y-1 moves to y-2, the new pixel to y-1
   assign lb_wr_en         = stage_valid_ff;
   assign lb_wr_addr       = x_ff;
   assign lb_wr_data.prev2 = lb_rd_data.prev;
   assign lb_wr_data.prev  = pix_ff;

   assign stage_valid = stage_valid_ff;

   // Candidate results in emission order
   always_comb begin
      va = flags_ff.y_ge2 && !flags_ff.x_is0;
      vb = flags_ff.y_ge2 && flags_ff.last_col;
      vc = flags_ff.y_is0 || flags_ff.last_row;

      ent_a.pix          = flags_ff.x_is1 ? vert_pix(center_ff)
                                          : full_pix(left_ff, center_ff, cur);
      ent_a.col          = COORD_W'(x_ff - 1'b1);
      ent_a.row          = COORD_W'(y_ff - 1'b1);
      ent_a.last_of_item = 1'b0;

      ent_b.pix          = vert_pix(cur);
      ent_b.col          = COORD_W'(x_ff);
      ent_b.row          = COORD_W'(y_ff - 1'b1);
      ent_b.last_of_item = 1'b0;

      ent_c.pix          = pix_ff;
      ent_c.col          = COORD_W'(x_ff);
      ent_c.row          = COORD_W'(y_ff);
      ent_c.last_of_item = 1'b0;
   end

   // Pack the valid results from slot 0 and mark the final one
   always_comb begin
      push.ent = '0;
      idx      = 2'd0;
      if (va) begin
         push.ent[idx] = ent_a;
         idx           = idx + 2'd1;
      end
      if (vb) begin
         push.ent[idx] = ent_b;
         idx           = idx + 2'd1;
      end
      if (vc) begin
         push.ent[idx] = ent_c;
         idx           = idx + 2'd1;
      end
      if (idx != 2'd0) begin
         push.ent[idx - 2'd1].last_of_item = 1'b1;
      end
      push.cnt = stage_valid_ff ? idx : 2'd0;
   end

endmodule

>>> hdl/bsm3_outq.sv
// Result queue: takes up to three results per cycle, hands out one per beat.
// Depends on bsm3_pkg.

module bsm3_outq (
   input  logic                            clock,
   input  logic                            reset,
   input  bsm3_pkg::push_type              push,
   input  logic                            pop,
   output logic                            head_valid,
   output bsm3_pkg::rsp_entry_type         head,
   output logic [bsm3_pkg::OUTQ_CW-1:0]    count
);
   import bsm3_pkg::*;

   rsp_entry_type      q_ff [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0] wr_ptr_ff;
   logic [OUTQ_AW-1:0] wr_ptr_in;
   logic [OUTQ_AW-1:0] rd_ptr_ff;
   logic [OUTQ_AW-1:0] rd_ptr_in;
   logic [OUTQ_CW-1:0] count_ff;
   logic [OUTQ_CW-1:0] count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + OUTQ_AW'(push.cnt);
      rd_ptr_in = pop ? rd_ptr_ff + OUTQ_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + OUTQ_CW'(push.cnt) - (pop ? OUTQ_CW'(1) : OUTQ_CW'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the packed results at the tail
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < push.cnt) begin
            q_ff[wr_ptr_ff + OUTQ_AW'(i)] <= push.ent[i];
         end
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = q_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

>>> hdl/binomial_3x3_rgb_smoother_top.sv
// Top level of the 3x3 binomial RGB smoother: size registers, raster counters,
// input admission, line buffer, filter stage and result queue.
// Depends on bsm3_pkg, bsm3_linebuf, bsm3_filter and bsm3_outq.
//
//   channel  | signals                                  | dir | transfer
//   ---------+------------------------------------------+-----+-------------------------
//   req      | req_valid/ready, req_chan0..2_in         | in  | one pixel per beat
//   rsp      | rsp_valid/ready, rsp_chan0..2_out,       | out | one result per beat
//            | rsp_out_column/row, rsp_last_of_item     |     |
//   csr      | csr_we, csr_addr, csr_wdata              | in  | write, no wait
//
// A pixel is accepted every cycle while each pixel causes at most one result and
// rsp_ready stays high; the first result of a pixel becomes visible once the filter
// stage has held the pixel and the result queue has stored the result. The last pixel
// of each filtered row causes two results and bottom-row pixels up to three; there the
// one-result-per-beat output sets the pace. req_ready drops when the result queue
// has no room for three more results behind those still in the stage.
// Reset is synchronous; the line buffer is not cleared, as row 0 writes it first.

module binomial_3x3_rgb_smoother_top #(
   parameter int MAX_WIDTH  = bsm3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bsm3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bsm3_pkg::CHAN_W-1:0]   req_chan0_in,
   input  logic [bsm3_pkg::CHAN_W-1:0]   req_chan1_in,
   input  logic [bsm3_pkg::CHAN_W-1:0]   req_chan2_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bsm3_pkg::CHAN_W-1:0]   rsp_chan0_out,
   output logic [bsm3_pkg::CHAN_W-1:0]   rsp_chan1_out,
   output logic [bsm3_pkg::CHAN_W-1:0]   rsp_chan2_out,
   output logic [bsm3_pkg::COORD_W-1:0]  rsp_out_column,
   output logic [bsm3_pkg::COORD_W-1:0]  rsp_out_row,
   output logic                          rsp_last_of_item,
   input  logic                          csr_we,
   input  logic [bsm3_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [bsm3_pkg::CFG_W-1:0]    csr_wdata
);
   import bsm3_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam logic [COL_W-1:0] W_LAST_RST = COL_W'(clamp_size(CFG_W'(DEF_WIDTH), MAX_WIDTH) - 1);
   localparam logic [ROW_W-1:0] H_LAST_RST =
      ROW_W'(clamp_size(CFG_W'(DEF_HEIGHT), MAX_HEIGHT) - 1);

   logic [COL_W-1:0] w_last_ff;
   logic [ROW_W-1:0] h_last_ff;
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic             accept;
   logic [OUTQ_CW:0] need;
   pixel_type        req_pix;
   pos_flags_type    flags;
   linepair_type     lb_rd_data;
   logic             lb_wr_en;
   logic [COL_W-1:0] lb_wr_addr;
   linepair_type     lb_wr_data;
   logic             stage_valid;
   push_type         push;
   rsp_entry_type    head;
   logic [OUTQ_CW-1:0] q_count;

   assign req_pix = {req_chan2_in, req_chan1_in, req_chan0_in};
   assign accept  = req_valid && req_ready;

   // Admit a pixel only when the queue can hold the stage's and this pixel's results
   always_comb begin
      need = (OUTQ_CW+1)'(q_count)
           + (stage_valid ? (OUTQ_CW+1)'(2 * MAX_RESULTS) : (OUTQ_CW+1)'(MAX_RESULTS));
      req_ready = (need <= (OUTQ_CW+1)'(OUTQ_DEPTH));
   end

   // Position flags of the pixel at the counters
   always_comb begin
      flags.x_is0    = (col_ff == '0);
      flags.x_is1    = (col_ff == COL_W'(1));
      flags.y_is0    = (row_ff == '0);
      flags.y_ge2    = (row_ff >= ROW_W'(2));
      flags.last_col = (col_ff >= w_last_ff);
      flags.last_row = (row_ff >= h_last_ff);
   end

   // Raster counters: wrap the column at the row end, the row at the frame end
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (flags.last_col) begin
            col_in = '0;
            row_in = flags.last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // Size registers; a write to either of them restarts the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         w_last_ff <= W_LAST_RST;
         h_last_ff <= H_LAST_RST;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_IMAGE_WIDTH: begin
               w_last_ff <= COL_W'(clamp_size(csr_wdata, MAX_WIDTH) - 1);
               col_ff    <= '0;
               row_ff    <= '0;
            end
            REG_IMAGE_HEIGHT: begin
               h_last_ff <= ROW_W'(clamp_size(csr_wdata, MAX_HEIGHT) - 1);
               col_ff    <= '0;
               row_ff    <= '0;
            end
            default: begin
               // no register behind this index: keep counting
               col_ff <= col_in;
               row_ff <= row_in;
            end
         endcase
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Consecutive pixels of one frame never share a column (width is at least 3), so
   // the write-back of one pixel cannot collide with the read of the next.
   bsm3_linebuf #(
      .DEPTH (MAX_WIDTH),
      .AW    (COL_W)
   ) u_linebuf (
      .clock      (clock),
      .rd_en      (accept),
      .rd_addr    (col_ff),
      .rd_data_ff (lb_rd_data),
      .wr_en      (lb_wr_en),
      .wr_addr    (lb_wr_addr),
      .wr_data    (lb_wr_data)
   );

   bsm3_filter #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .COL_W      (COL_W),
      .ROW_W      (ROW_W)
   ) u_filter (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pix         (req_pix),
      .x           (col_ff),
      .y           (row_ff),
      .flags       (flags),
      .lb_rd_data  (lb_rd_data),
      .lb_wr_en    (lb_wr_en),
      .lb_wr_addr  (lb_wr_addr),
      .lb_wr_data  (lb_wr_data),
      .stage_valid (stage_valid),
      .push        (push)
   );

   bsm3_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_valid && rsp_ready),
      .head_valid (rsp_valid),
      .head       (head),
      .count      (q_count)
   );

   assign rsp_chan0_out    = head.pix[CHAN_W-1:0];
   assign rsp_chan1_out    = head.pix[2*CHAN_W-1:CHAN_W];
   assign rsp_chan2_out    = head.pix[3*CHAN_W-1:2*CHAN_W];
   assign rsp_out_column   = head.col;
   assign rsp_out_row      = head.row;
   assign rsp_last_of_item = head.last_of_item;

endmodule

>>> hdl/bsm3_checker.sv
// Port-level checks for the smoother's result channel, bound to the top level.
// Depends on bsm3_pkg and binomial_3x3_rgb_smoother_top.

module bsm3_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bsm3_pkg::CHAN_W-1:0]   rsp_chan0_out,
   input logic [bsm3_pkg::CHAN_W-1:0]   rsp_chan1_out,
   input logic [bsm3_pkg::CHAN_W-1:0]   rsp_chan2_out,
   input logic [bsm3_pkg::COORD_W-1:0]  rsp_out_column,
   input logic [bsm3_pkg::COORD_W-1:0]  rsp_out_row,
   input logic                          rsp_last_of_item
);
   import bsm3_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the beat was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_chan0_out) && $stable(rsp_chan1_out)
         && $stable(rsp_chan2_out) && $stable(rsp_out_column)
         && $stable(rsp_out_row) && $stable(rsp_last_of_item))
      else $error("stalled result beat changed");

   // All results of a pixel are queued together: a non-final beat has a successor
   a_rsp_group: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_item |=> rsp_valid)
      else $error("result group broken after a non-final beat");

   // An empty result channel wakes up only once an accepted pixel has passed the filter stage into the result queue
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without an accepted pixel");

endmodule

bind binomial_3x3_rgb_smoother_top bsm3_checker u_bsm3_checker (.*);
